/* sv/thdm_pkg.sv */
// Shared constants, types and command/status structs for the tap-hold modifier block.
`default_nettype none
package thdm_pkg;

    localparam int DUAL_BASE = 49152;
    localparam int NUM_MODS  = 8;
    localparam int MOD_SLOTS = 8;

    localparam logic [16:0] DUAL_LO = 17'(DUAL_BASE);
    localparam logic [16:0] DUAL_HI = 17'(DUAL_BASE + NUM_MODS * 256 - 1);
    localparam logic [15:0] DUAL_BASE_CODE = 16'(DUAL_BASE);
    localparam logic [15:0] MOD_KEY_BASE = 16'h00E0;

    localparam logic [7:0] TIMEOUT_RESET = 8'd80;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLE      = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_MOD = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

    typedef enum logic [1:0] {
        KIND_RETURN = 2'd0,
        KIND_MOD    = 2'd1,
        KIND_TAP    = 2'd2
    } kind_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic emit_mod;
        logic emit_tap;
        logic emit_last;
    } ctl_cmd_t;

    typedef struct packed {
        logic mods_pending;
        logic tap_first;
        logic out_free;
    } ctl_status_t;

endpackage
`default_nettype wire

/* sv/thdm_ctrl.sv */
// Sequencer for one key event: load, evaluate, emit modifier presses, tap, final word.
`default_nettype none
module thdm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire thdm_pkg::ctl_status_t status,
    output thdm_pkg::ctl_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MODS,
        S_TAP,
        S_LAST
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_MODS;
            end
            S_MODS:
            begin
                if (status.mods_pending)
                begin
                    cmd.emit_mod = status.out_free;
                end
                else
                begin
                    state_next = status.tap_first ? S_TAP : S_LAST;
                end
            end
            S_TAP:
            begin
                if (status.out_free)
                begin
                    cmd.emit_tap = 1'b1;
                    state_next   = S_LAST;
                end
            end
            S_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* sv/thdm_datapath.sv */
// Event latch, key state, config registers and output word register.
`default_nettype none
module thdm_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire thdm_pkg::ctl_cmd_t    cmd,
    output thdm_pkg::ctl_status_t      status,
    input  wire logic                  cfg_valid,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [7:0]            cfg_data,
    input  wire logic [15:0]           key_code,
    input  wire logic                  now_pressed,
    input  wire logic                  before_pressed,
    input  wire logic                  injected_flag,
    input  wire logic [7:0]            key_row,
    input  wire logic [7:0]            key_col,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 out_kind,
    output logic [15:0]                out_key,
    output logic [7:0]                 out_row,
    output logic [7:0]                 out_col,
    output logic                       last
);

    // config
    logic       enable_reg;
    logic       default_mod_reg;
    logic [7:0] timeout_reg;

    // latched event
    logic [15:0] code_reg;
    logic        now_reg;
    logic        before_reg;
    logic        inj_reg;
    logic [7:0]  row_reg;
    logic [7:0]  col_reg;

    // key state
    logic [7:0] action_reg, action_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] timer_reg [thdm_pkg::MOD_SLOTS];
    logic [7:0] timer_wr;
    logic       timer_we;

    // plan for the emit phase
    logic [7:0]  mods_reg, mods_next;
    logic        tap_reg, tap_next;
    logic [15:0] final_reg, final_next;
    logic [15:0] tap_key_reg;

    // output word register
    logic              out_valid_reg;
    thdm_pkg::kind_t   out_kind_reg;
    logic [15:0]       out_key_reg;
    logic [7:0]        out_row_reg;
    logic [7:0]        out_col_reg;
    logic              last_reg;

    logic        dual;
    logic [15:0] diff;
    logic [2:0]  idx;
    logic [7:0]  bitmask;
    logic [15:0] tap16;
    logic [15:0] mod_key;
    logic [7:0]  tmr;
    logic [7:0]  tmr_inc;
    logic        out_free;
    logic [7:0]  low_onehot;
    logic [2:0]  low_pos;

    assign dual = ({1'b0, code_reg} >= thdm_pkg::DUAL_LO) &&
                  ({1'b0, code_reg} <= thdm_pkg::DUAL_HI);
    assign diff    = code_reg - thdm_pkg::DUAL_BASE_CODE;
    assign idx     = dual ? diff[10:8] : 3'd0;
    assign bitmask = dual ? (8'd1 << idx) : 8'd0;
    assign tap16   = dual ? {8'd0, diff[7:0]} : 16'd0;
    assign mod_key = thdm_pkg::MOD_KEY_BASE | {13'd0, idx};
    assign tmr     = timer_reg[idx];
    assign tmr_inc = (tmr < timeout_reg) ? tmr + 8'd1 : tmr;

    assign out_free = !out_valid_reg || out_ready;

    // lowest pending modifier
    assign low_onehot = mods_reg & (~mods_reg + 8'd1);
    always_comb
    begin
        low_pos = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (low_onehot[i])
            begin
                low_pos = low_pos | 3'(i);
            end
        end
    end

    // event decision
    always_comb
    begin
        action_next = action_reg;
        held_next   = held_reg;
        timer_we    = 1'b0;
        timer_wr    = tmr_inc;
        mods_next   = 8'd0;
        tap_next    = 1'b0;
        final_next  = code_reg;
        if (!enable_reg)
        begin
            if (dual)
            begin
                final_next = default_mod_reg ? mod_key : tap16;
            end
        end
        else if (inj_reg)
        begin
            final_next = code_reg;
        end
        else if (!now_reg && !before_reg)
        begin
            final_next = dual ? 16'd0 : code_reg;
        end
        else if (!dual)
        begin
            mods_next = now_reg ? held_reg : 8'd0;
        end
        else
        begin
            held_next = now_reg ? (held_reg | bitmask) : (held_reg & ~bitmask);
            timer_we  = 1'b1;
            if (now_reg && !before_reg)
            begin
                action_next = action_reg | bitmask;
                final_next  = 16'd0;
            end
            else if (tmr_inc >= timeout_reg)
            begin
                action_next = action_reg | bitmask;
                mods_next   = held_next;
                timer_wr    = now_reg ? tmr_inc : 8'd0;
                final_next  = 16'd0;
            end
            else if (!now_reg)
            begin
                action_next = action_reg & ~bitmask;
                timer_wr    = 8'd0;
                tap_next    = 1'b1;
                final_next  = tap16;
            end
            else
            begin
                final_next = ((action_reg & bitmask) != 8'd0) ? mod_key : 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b1;
            default_mod_reg <= 1'b0;
            timeout_reg     <= thdm_pkg::TIMEOUT_RESET;
            action_reg      <= 8'd0;
            held_reg        <= 8'd0;
            for (int i = 0; i < thdm_pkg::MOD_SLOTS; i++)
            begin
                timer_reg[i] <= 8'd0;
            end
            mods_reg        <= 8'd0;
            tap_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    thdm_pkg::CFG_ENABLE:      enable_reg      <= cfg_data[0];
                    thdm_pkg::CFG_DEFAULT_MOD: default_mod_reg <= cfg_data[0];
                    thdm_pkg::CFG_TIMEOUT:     timeout_reg     <= cfg_data;
                    default:                   ;
                endcase
            end
            if (cmd.eval)
            begin
                action_reg <= action_next;
                held_reg   <= held_next;
                if (timer_we)
                begin
                    timer_reg[idx] <= timer_wr;
                end
                mods_reg <= mods_next;
                tap_reg  <= tap_next;
            end
            else if (cmd.emit_mod)
            begin
                mods_reg <= mods_reg & ~low_onehot;
            end
            if (cmd.emit_mod || cmd.emit_tap || cmd.emit_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg   <= key_code;
            now_reg    <= now_pressed;
            before_reg <= before_pressed;
            inj_reg    <= injected_flag;
            row_reg    <= key_row;
            col_reg    <= key_col;
        end
        if (cmd.eval)
        begin
            final_reg   <= final_next;
            tap_key_reg <= tap16;
        end
        if (cmd.emit_mod)
        begin
            out_kind_reg <= thdm_pkg::KIND_MOD;
            out_key_reg  <= thdm_pkg::MOD_KEY_BASE | {13'd0, low_pos};
            last_reg     <= 1'b0;
        end
        else if (cmd.emit_tap)
        begin
            out_kind_reg <= thdm_pkg::KIND_TAP;
            out_key_reg  <= tap_key_reg;
            last_reg     <= 1'b0;
        end
        else if (cmd.emit_last)
        begin
            out_kind_reg <= thdm_pkg::KIND_RETURN;
            out_key_reg  <= final_reg;
            last_reg     <= 1'b1;
        end
        if (cmd.emit_mod || cmd.emit_tap || cmd.emit_last)
        begin
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
        end
    end

    assign status.mods_pending = (mods_reg != 8'd0);
    assign status.tap_first    = tap_reg;
    assign status.out_free     = out_free;

    assign out_valid = out_valid_reg;
    assign out_kind  = 2'(out_kind_reg);
    assign out_key   = out_key_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

/* sv/tap_hold_dual_role_modifier_core.sv */
// Top level: a key event is taken, evaluated once, then its words leave one at a time through
// the output register, modifier presses first, then a tap, then the final word; the sequencer
// takes no new event until that final word has been issued.
// Reset (rst_n low, async): enable 1, default_to_modifier 0, hold_timeout 80,
// all key maps and hold timers cleared, output empty.
`default_nettype none
module tap_hold_dual_role_modifier_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] key_code,
    input  wire logic        now_pressed,
    input  wire logic        before_pressed,
    input  wire logic        injected_flag,
    input  wire logic [7:0]  key_row,
    input  wire logic [7:0]  key_col,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       out_kind,
    output logic [15:0]      out_key,
    output logic [7:0]       out_row,
    output logic [7:0]       out_col,
    output logic             last
);

    thdm_pkg::ctl_cmd_t    cmd;
    thdm_pkg::ctl_status_t status;

    assign cfg_ready = 1'b1;

    thdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    thdm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .key_code       (key_code),
        .now_pressed    (now_pressed),
        .before_pressed (before_pressed),
        .injected_flag  (injected_flag),
        .key_row        (key_row),
        .key_col        (key_col),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_kind       (out_kind),
        .out_key        (out_key),
        .out_row        (out_row),
        .out_col        (out_col),
        .last           (last)
    );

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the tap-hold dual-role modifier core.
module testbench;

    localparam int PRESSURE_AT     = 150;
    localparam int PRESSURE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int TAIL_CYCLES     = 12;

    typedef struct packed {
        logic [15:0] code;
        logic        now;
        logic        prev;
        logic        inj;
        logic [7:0]  row;
        logic [7:0]  col;
    } key_evt_t;

    typedef struct packed {
        thdm_pkg::kind_t kind;
        logic [15:0]     key;
        logic [7:0]      row;
        logic [7:0]      col;
        logic            last_flag;
    } key_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] key_code = '0;
    logic        now_pressed = 1'b0;
    logic        before_pressed = 1'b0;
    logic        injected_flag = 1'b0;
    logic [7:0]  key_row = '0;
    logic [7:0]  key_col = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  out_kind;
    logic [15:0] out_key;
    logic [7:0]  out_row;
    logic [7:0]  out_col;
    logic        last;

    // predictor copy of the registers and key state
    logic       en_r = 1'b1;
    logic       dflt_mod_r = 1'b0;
    logic [7:0] timeout_r = thdm_pkg::TIMEOUT_RESET;
    logic [7:0] action_r = '0;
    logic [7:0] held_r = '0;
    logic [7:0] timer_r [thdm_pkg::MOD_SLOTS] = '{default: '0};

    key_evt_t  key_events [$];
    key_word_t expected_words [$];
    key_evt_t  cur_evt = '0;
    key_word_t got_word;

    int events_queued = 0;
    int events_in = 0;
    int words_due = 0;
    int words_seen = 0;
    int mismatches = 0;
    int settings_used = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    logic pressure_done = 1'b0;
    logic steady = 1'b0;

    tap_hold_dual_role_modifier_core dut (.*);

    always #1 clk = ~clk;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] dual_code(int m, int t);
        return thdm_pkg::DUAL_BASE_CODE + 16'(m * 256 + t);
    endfunction

    function automatic void put_word(thdm_pkg::kind_t kind, logic [15:0] key, logic fin,
                                     key_evt_t e);
        key_word_t w;
        w.kind = kind;
        w.key = key;
        w.row = e.row;
        w.col = e.col;
        w.last_flag = fin;
        expected_words.push_back(w);
    endfunction

    function automatic void put_held_mods(key_evt_t e);
        for (int k = 0; k < thdm_pkg::NUM_MODS; k++)
            if (held_r[k])
                put_word(thdm_pkg::KIND_MOD, thdm_pkg::MOD_KEY_BASE + 16'(k), 1'b0, e);
    endfunction

    // works out the words one key event produces; returns how many
    function automatic int predict_words(key_evt_t e);
        logic        dual;
        logic [15:0] off;
        logic [2:0]  m;
        logic [7:0]  mbit;
        logic [15:0] tap;
        int          n;
        n = expected_words.size();
        dual = ({1'b0, e.code} >= thdm_pkg::DUAL_LO) && ({1'b0, e.code} <= thdm_pkg::DUAL_HI);
        off = e.code - thdm_pkg::DUAL_BASE_CODE;
        m = off[10:8];
        mbit = 8'd1 << m;
        tap = {8'h00, off[7:0]};
        if (!en_r)
        begin
            if (dual)
                put_word(thdm_pkg::KIND_RETURN,
                         dflt_mod_r ? thdm_pkg::MOD_KEY_BASE + 16'(m) : tap, 1'b1, e);
            else
                put_word(thdm_pkg::KIND_RETURN, e.code, 1'b1, e);
        end
        else if (e.inj)
        begin
            put_word(thdm_pkg::KIND_RETURN, e.code, 1'b1, e);
        end
        else if (!e.now && !e.prev)
        begin
            put_word(thdm_pkg::KIND_RETURN, dual ? 16'h0000 : e.code, 1'b1, e);
        end
        else if (!dual)
        begin
            if (e.now)
                put_held_mods(e);
            put_word(thdm_pkg::KIND_RETURN, e.code, 1'b1, e);
        end
        else
        begin
            if (e.now)
                held_r = held_r | mbit;
            else
                held_r = held_r & ~mbit;
            if (e.now && !e.prev)
            begin
                action_r = action_r | mbit;
                if (timer_r[m] < timeout_r)
                    timer_r[m] = timer_r[m] + 8'd1;
                put_word(thdm_pkg::KIND_RETURN, 16'h0000, 1'b1, e);
            end
            else
            begin
                // timer saturates at the timeout, so a zero timeout is already expired
                if (timer_r[m] < timeout_r)
                    timer_r[m] = timer_r[m] + 8'd1;
                if (timer_r[m] >= timeout_r)
                begin
                    action_r = action_r | mbit;
                    put_held_mods(e);
                    if (!e.now)
                        timer_r[m] = '0;
                    put_word(thdm_pkg::KIND_RETURN, 16'h0000, 1'b1, e);
                end
                else if (!e.now)
                begin
                    action_r = action_r & ~mbit;
                    timer_r[m] = '0;
                    put_word(thdm_pkg::KIND_TAP, tap, 1'b0, e);
                    put_word(thdm_pkg::KIND_RETURN, tap, 1'b1, e);
                end
                else
                begin
                    put_word(thdm_pkg::KIND_RETURN,
                             action_r[m] ? thdm_pkg::MOD_KEY_BASE + 16'(m) : 16'h0000,
                             1'b1, e);
                end
            end
        end
        return expected_words.size() - n;
    endfunction

    function automatic void report_diff(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                words_due <= words_due + predict_words(cur_evt);
                events_in <= events_in + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (key_events.size() != 0)
                begin
                    cur_evt <= key_events[0];
                    key_code <= key_events[0].code;
                    now_pressed <= key_events[0].now;
                    before_pressed <= key_events[0].prev;
                    injected_flag <= key_events[0].inj;
                    key_row <= key_events[0].row;
                    key_col <= key_events[0].col;
                    void'(key_events.pop_front());
                    in_valid <= 1'b1;
                    gap_left <= steady ? 0 : draw_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                words_seen <= words_seen + 1;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got kind %h key %h",
                             $time, out_kind, out_key);
                    mismatches++;
                end
                else
                begin
                    got_word = expected_words.pop_front();
                    report_diff("out_kind", 16'(got_word.kind), 16'(out_kind));
                    report_diff("out_key", got_word.key, out_key);
                    report_diff("out_row", 16'(got_word.row), 16'(out_row));
                    report_diff("out_col", 16'(got_word.col), 16'(out_col));
                    report_diff("last", 16'(got_word.last_flag), 16'(last));
                end
            end
            // one long hold-off so the core backs up and stalls its input
            if (!pressure_done && events_in >= PRESSURE_AT)
            begin
                pressure_done <= 1'b1;
                hold_left <= PRESSURE_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left <= steady ? 0 : draw_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_evt(logic [15:0] code, logic now, logic prev, logic inj,
                           logic [7:0] row, logic [7:0] col);
        key_evt_t e;
        e.code = code;
        e.now = now;
        e.prev = prev;
        e.inj = inj;
        e.row = row;
        e.col = col;
        key_events.push_back(e);
        events_queued++;
    endtask

    task automatic add_key(logic [15:0] code, logic now, logic prev);
        add_evt(code, now, prev, 1'b0, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        while (events_in != events_queued || words_seen < words_due)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            thdm_pkg::CFG_ENABLE:      en_r = val[0];
            thdm_pkg::CFG_DEFAULT_MOD: dflt_mod_r = val[0];
            thdm_pkg::CFG_TIMEOUT:     timeout_r = val;
            default:                   ;
        endcase
    endtask

    task automatic apply_settings(logic en, logic dm, logic [7:0] tmo);
        wait_drained();
        cfg_write(thdm_pkg::CFG_ENABLE, {7'b0, en});
        cfg_write(thdm_pkg::CFG_DEFAULT_MOD, {7'b0, dm});
        cfg_write(thdm_pkg::CFG_TIMEOUT, tmo);
        settings_used++;
        @(negedge clk);
    endtask

    // mostly press / hold / release runs of dual keys, the rest random events
    task automatic run_phase(int count, int max_hold);
        int          target;
        int          holds;
        logic [15:0] code;
        target = events_queued + count;
        while (events_queued < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                code = dual_code($urandom_range(0, thdm_pkg::NUM_MODS - 1),
                                 $urandom_range(0, 255));
                add_key(code, 1'b1, 1'b0);
                holds = $urandom_range(0, max_hold);
                for (int h = 0; h < holds; h++)
                begin
                    add_key(code, 1'b1, 1'b1);
                    if ($urandom_range(0, 3) == 0)
                        add_key(16'($urandom_range(0, 16'hBFFF)), 1'b1, 1'($urandom));
                    if ($urandom_range(0, 7) == 0)
                        add_key(dual_code($urandom_range(0, thdm_pkg::NUM_MODS - 1),
                                          $urandom_range(0, 255)), 1'b1, 1'b0);
                end
                if ($urandom_range(0, 9) != 0)
                    add_key(code, 1'b0, 1'b1);
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    code = dual_code($urandom_range(0, thdm_pkg::NUM_MODS - 1),
                                     $urandom_range(0, 255));
                else
                    code = 16'($urandom);
                add_evt(code, 1'($urandom), 1'($urandom), $urandom_range(0, 3) == 0,
                        8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: injected, idle, range edges, tap, held modifiers
        add_evt(16'hC000, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00);
        add_evt(16'hC7FF, 1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF);
        add_evt(16'hFFFF, 1'b0, 1'b0, 1'b0, 8'h5A, 8'hA5);
        add_key(16'hBFFF, 1'b1, 1'b0);
        add_key(dual_code(0, 4), 1'b1, 1'b0);
        add_key(dual_code(0, 4), 1'b1, 1'b1);
        add_key(16'hC800, 1'b1, 1'b1);
        add_key(16'hC800, 1'b0, 1'b1);
        add_key(dual_code(0, 4), 1'b0, 1'b1);
        add_key(dual_code(1, 'h29), 1'b1, 1'b1);
        add_key(dual_code(0, 0), 1'b1, 1'b0);
        for (int m = 2; m < thdm_pkg::NUM_MODS; m++)
            add_key(dual_code(m, m), 1'b1, 1'b0);
        // all eight modifiers held: nine words for one key press
        add_key(16'h0000, 1'b1, 1'b0);
        add_evt(16'h0004, 1'b1, 1'b1, 1'b1, 8'h12, 8'h34);

        apply_settings(1'b1, 1'b0, 8'd1);
        add_key(dual_code(2, 2), 1'b1, 1'b1);
        add_key(dual_code(2, 2), 1'b0, 1'b1);
        apply_settings(1'b1, 1'b0, 8'd0);
        add_key(dual_code(3, 3), 1'b0, 1'b1);
        add_key(dual_code(3, 3), 1'b1, 1'b0);
        apply_settings(1'b0, 1'b1, 8'd0);
        add_evt(dual_code(7, 255), 1'b1, 1'b1, 1'b1, 8'h80, 8'h01);
        apply_settings(1'b0, 1'b0, 8'd80);
        add_key(dual_code(5, 5), 1'b0, 1'b0);
        add_key(16'h1234, 1'b1, 1'b0);

        apply_settings(1'b1, 1'b0, 8'd3);
        run_phase(40, 6);
        apply_settings(1'b1, 1'b1, 8'd1);
        run_phase(30, 3);
        apply_settings(1'b1, 1'b0, 8'd0);
        run_phase(20, 3);
        apply_settings(1'b1, 1'b0, 8'd255);
        run_phase(25, 10);
        // hold long enough for the timer to reach its ceiling
        add_key(dual_code(6, 'h33), 1'b1, 1'b0);
        for (int h = 0; h < 258; h++)
            add_key(dual_code(6, 'h33), 1'b1, 1'b1);
        add_key(dual_code(6, 'h33), 1'b0, 1'b1);
        apply_settings(1'b1, 1'b0, 8'd5);
        steady = 1'b1;
        run_phase(40, 8);
        apply_settings(1'b0, 1'b1, 8'd5);
        steady = 1'b0;
        run_phase(20, 4);
        apply_settings(1'b0, 1'b0, 8'd5);
        run_phase(20, 4);
        apply_settings(1'b1, 1'b0, thdm_pkg::TIMEOUT_RESET);
        run_phase(20, 12);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d key events and %0d result words over %0d register settings,",
                 events_in, words_seen, settings_used + 1);
        $display("with random gaps on both sides and one long output hold-off.");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

/* files.f */
sv/thdm_pkg.sv
sv/thdm_ctrl.sv
sv/thdm_datapath.sv
sv/tap_hold_dual_role_modifier_core.sv
tb/sv/testbench.sv
